/* rtl/core/gmd_pkg.sv */
// Package with the shared constants, types and codes of the gyro motion detector.
package gmd_pkg;

  // Samples held per axis in the sliding window.
  localparam int WINDOW     = 10;
  // Samples that remain after the minimum and maximum are dropped.
  localparam int TRIM_N     = WINDOW - 2;
  localparam int IDX_W      = $clog2(WINDOW);
  localparam int ROOT_STEPS = 16;
  localparam int CNT_W      = (IDX_W > 4) ? IDX_W : 4;

  // Signed window sum, and magnitude of the trimmed sum.
  localparam int ACC_W      = $clog2(WINDOW) + 17;
  localparam int MAG_W      = $clog2(TRIM_N) + 16;

  // Division by TRIM_N as a multiplication by a rounded-up reciprocal.
  localparam int     DIV_SHIFT = MAG_W + $clog2(TRIM_N);
  localparam longint DIV_MULT  = ((longint'(1) << DIV_SHIFT) + TRIM_N - 1) / TRIM_N;
  localparam int     PROD_W    = 2 * MAG_W + 1;
  localparam int     Q_W       = PROD_W - DIV_SHIFT;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] SENS_RST       = 16'd260;
  localparam logic [9:0]  PERIOD_LEN_RST = 10'd1000;
  localparam logic [9:0]  BAD_LIMIT_RST  = 10'd2;
  localparam logic [1:0]  AXIS_LAST      = 2'd2;

  typedef logic signed [15:0] s16_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS       = 3'd0,
    REG_ZERO_X     = 3'd1,
    REG_ZERO_Y     = 3'd2,
    REG_ZERO_Z     = 3'd3,
    REG_PERIOD_LEN = 3'd4,
    REG_BAD_LIMIT  = 3'd5
  } reg_idx_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TRIM,
    ST_DIV,
    ST_DEV,
    ST_SQR,
    ST_RINIT,
    ST_ROOT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [15:0] sensitivity;
    s16_t        zero_x;
    s16_t        zero_y;
    s16_t        zero_z;
    logic [9:0]  period_length;
    logic [9:0]  bad_move_limit;
  } cfg_t;

  typedef struct packed {
    logic             load_sample;
    logic             scan_en;
    logic             scan_first;
    logic [IDX_W-1:0] scan_idx;
    logic [1:0]       axis;
    logic             trim_en;
    logic             div_en;
    logic             dev_en;
    logic             sq_en;
    logic             root_init;
    logic             root_en;
    logic             finish;
    logic             clear_op;
  } cmd_t;

endpackage

/* rtl/core/gmd_if.sv */
// Channel interfaces of the gyro motion detector: sample, result and configuration.
interface gmd_sample_if;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;

  modport source (output valid, opcode, gyro_x, gyro_y, gyro_z, input ready);
  modport sink   (input valid, opcode, gyro_x, gyro_y, gyro_z, output ready);
endinterface

interface gmd_result_if;
  logic        valid;
  logic        ready;
  logic        move_detected;
  logic [15:0] motion_magnitude;
  logic        period_end;
  logic        period_bad;
  logic [15:0] good_total;
  logic [15:0] bad_total;

  modport source (output valid, move_detected, motion_magnitude, period_end, period_bad,
                  good_total, bad_total, input ready);
  modport sink   (input valid, move_detected, motion_magnitude, period_end, period_bad,
                  good_total, bad_total, output ready);
endinterface

interface gmd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/gmd_cfg.sv */
// Configuration register file of the gyro motion detector.
module gmd_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_valid_i,
  input  logic [gmd_pkg::CFG_IDX_W-1:0]     wr_index_i,
  input  logic [gmd_pkg::CFG_DATA_W-1:0]    wr_data_i,
  output logic                              wr_ready_o,
  output gmd_pkg::cfg_t                     cfg_o
);
  import gmd_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      unique case (wr_index_i)
        REG_SENS:       cfg_d.sensitivity    = wr_data_i;
        REG_ZERO_X:     cfg_d.zero_x         = wr_data_i;
        REG_ZERO_Y:     cfg_d.zero_y         = wr_data_i;
        REG_ZERO_Z:     cfg_d.zero_z         = wr_data_i;
        REG_PERIOD_LEN: cfg_d.period_length  = wr_data_i[9:0];
        REG_BAD_LIMIT:  cfg_d.bad_move_limit = wr_data_i[9:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensitivity    <= SENS_RST;
      cfg_q.zero_x         <= '0;
      cfg_q.zero_y         <= '0;
      cfg_q.zero_z         <= '0;
      cfg_q.period_length  <= PERIOD_LEN_RST;
      cfg_q.bad_move_limit <= BAD_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* rtl/core/gmd_ctrl.sv */
// Sequencing state machine and output handshake of the gyro motion detector.
module gmd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_opcode_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output gmd_pkg::cmd_t cmd_o
);
  import gmd_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [1:0]        axis_q, axis_d;
  logic              clr_q, clr_d;
  logic              out_valid_q, out_valid_d;

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      axis_q      <= '0;
      clr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      axis_q      <= axis_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    axis_d           = axis_q;
    clr_d            = clr_q;
    out_valid_d      = out_valid_q && !out_ready_i;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.scan_idx   = cnt_q[IDX_W-1:0];
    cmd_o.axis       = axis_q;
    cmd_o.clear_op   = clr_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (op_e'(in_opcode_i) == OP_CLEAR) begin
            clr_d   = 1'b1;
            state_d = ST_FIN;
          end else begin
            clr_d             = 1'b0;
            cmd_o.load_sample = 1'b1;
            cnt_d             = '0;
            state_d           = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en    = 1'b1;
        cmd_o.scan_first = (cnt_q == '0);
        if (cnt_q == CNT_W'(WINDOW - 1)) begin
          cnt_d   = '0;
          axis_d  = '0;
          state_d = ST_TRIM;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_TRIM: begin
        cmd_o.trim_en = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_en = 1'b1;
        state_d      = ST_DEV;
      end
      ST_DEV: begin
        cmd_o.dev_en = 1'b1;
        state_d      = ST_SQR;
      end
      ST_SQR: begin
        cmd_o.sq_en = 1'b1;
        if (axis_q == AXIS_LAST) begin
          state_d = ST_RINIT;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = ST_TRIM;
        end
      end
      ST_RINIT: begin
        cmd_o.root_init = 1'b1;
        cnt_d           = '0;
        state_d         = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_en = 1'b1;
        if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/gmd_dp.sv */
// Datapath of the gyro motion detector: window, trimmed mean, root and period counters.
module gmd_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gmd_pkg::cmd_t cmd_i,
  input  gmd_pkg::cfg_t cfg_i,
  input  gmd_pkg::s16_t gyro_x_i,
  input  gmd_pkg::s16_t gyro_y_i,
  input  gmd_pkg::s16_t gyro_z_i,
  output logic          move_detected_o,
  output logic [15:0]   motion_magnitude_o,
  output logic          period_end_o,
  output logic          period_bad_o,
  output logic [15:0]   good_total_o,
  output logic [15:0]   bad_total_o
);
  import gmd_pkg::*;

  s16_t                    win_q [WINDOW][3];
  logic [IDX_W-1:0]        slot_q;
  logic signed [ACC_W-1:0] sum_q [3];
  s16_t                    lo_q [3];
  s16_t                    hi_q [3];
  logic [MAG_W-1:0]        tmag_q;
  logic [PROD_W-1:0]       prod_q;
  logic [Q_W-1:0]          ad_q;
  logic [31:0]             sq_q;
  logic [31:0]             v_q, res_q, bit_q;
  logic [9:0]              ps_q, pm_q;
  logic [15:0]             good_q, bad_q;

  logic                    move_q, pend_q, pbad_q;
  logic [15:0]             mag_q;

  s16_t                    rd [3];
  logic signed [ACC_W-1:0] trim;
  logic [ACC_W-1:0]        trim_abs;
  s16_t                    zsel;
  logic [16:0]             zabs;
  logic [Q_W-1:0]          quot;
  logic signed [17:0]      dev;
  logic [17:0]             dev_abs;
  logic [33:0]             sq_term;
  logic [32:0]             root_try;
  logic                    root_ge;
  logic [15:0]             mag;
  logic                    move;
  logic [9:0]              pm_next, ps_next;
  logic                    pend, pbad;

  // Window read at the scan index, all three axes at once.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rd[a] = win_q[cmd_i.scan_idx][a];
    end
  end

  always_comb begin
    trim     = sum_q[cmd_i.axis] - ACC_W'(lo_q[cmd_i.axis]) - ACC_W'(hi_q[cmd_i.axis]);
    trim_abs = trim[ACC_W-1] ? ACC_W'(-trim) : ACC_W'(trim);

    unique case (cmd_i.axis)
      2'd0:    zsel = cfg_i.zero_x;
      2'd1:    zsel = cfg_i.zero_y;
      default: zsel = cfg_i.zero_z;
    endcase
    zabs = zsel[15] ? 17'(-{zsel[15], zsel}) : {1'b0, zsel};

    // The magnitude quotient is already the absolute value of the mean.
    quot    = prod_q[PROD_W-1:DIV_SHIFT];
    dev     = $signed({1'b0, quot}) - $signed({1'b0, zabs});
    dev_abs = dev[17] ? 18'(-dev) : 18'(dev);
    sq_term = ad_q * ad_q;

    root_try = {1'b0, res_q} + {1'b0, bit_q};
    root_ge  = {1'b0, v_q} >= root_try;

    mag     = res_q[15:0];
    move    = mag > cfg_i.sensitivity;
    pm_next = (move && (pm_q != 10'h3FF)) ? pm_q + 10'd1 : pm_q;
    ps_next = ps_q + 10'd1;
    pend    = ps_next >= cfg_i.period_length;
    pbad    = pend && (pm_next >= cfg_i.bad_move_limit);
  end

  // Sliding window and its write slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        for (int a = 0; a < 3; a++) begin
          win_q[i][a] <= '0;
        end
      end
      slot_q <= '0;
    end else if (cmd_i.load_sample) begin
      win_q[slot_q][0] <= gyro_x_i;
      win_q[slot_q][1] <= gyro_y_i;
      win_q[slot_q][2] <= gyro_z_i;
      slot_q <= (slot_q == IDX_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
    end
  end

  // Arithmetic working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en) begin
      for (int a = 0; a < 3; a++) begin
        if (cmd_i.scan_first) begin
          sum_q[a] <= ACC_W'(rd[a]);
          lo_q[a]  <= rd[a];
          hi_q[a]  <= rd[a];
        end else begin
          sum_q[a] <= sum_q[a] + ACC_W'(rd[a]);
          if (rd[a] < lo_q[a]) lo_q[a] <= rd[a];
          if (rd[a] > hi_q[a]) hi_q[a] <= rd[a];
        end
      end
    end
    if (cmd_i.trim_en) tmag_q <= trim_abs[MAG_W-1:0];
    if (cmd_i.div_en)  prod_q <= PROD_W'(tmag_q) * PROD_W'(DIV_MULT);
    if (cmd_i.dev_en)  ad_q   <= dev_abs[Q_W-1:0];
    if (cmd_i.load_sample) begin
      sq_q <= '0;
    end else if (cmd_i.sq_en) begin
      sq_q <= sq_q + sq_term[31:0];
    end
    if (cmd_i.root_init) begin
      v_q   <= sq_q;
      res_q <= '0;
      bit_q <= 32'h4000_0000;
    end else if (cmd_i.root_en) begin
      if (root_ge) begin
        v_q   <= v_q - root_try[31:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // Period statistics.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q   <= '0;
      pm_q   <= '0;
      good_q <= '0;
      bad_q  <= '0;
    end else if (cmd_i.finish) begin
      if (cmd_i.clear_op) begin
        good_q <= '0;
        bad_q  <= '0;
      end else if (pend) begin
        ps_q <= '0;
        pm_q <= '0;
        if (pbad) begin
          if (bad_q != 16'hFFFF) bad_q <= bad_q + 16'd1;
        end else begin
          if (good_q != 16'hFFFF) good_q <= good_q + 16'd1;
        end
      end else begin
        ps_q <= ps_next;
        pm_q <= pm_next;
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (cmd_i.clear_op) begin
        move_q <= 1'b0;
        mag_q  <= '0;
        pend_q <= 1'b0;
        pbad_q <= 1'b0;
      end else begin
        move_q <= move;
        mag_q  <= mag;
        pend_q <= pend;
        pbad_q <= pbad;
      end
    end
  end

  assign move_detected_o    = move_q;
  assign motion_magnitude_o = mag_q;
  assign period_end_o       = pend_q;
  assign period_bad_o       = pbad_q;
  assign good_total_o       = good_q;
  assign bad_total_o        = bad_q;

endmodule

/* rtl/core/gyro_motion_detector.sv */
// Top level of the gyro motion detector: trimmed-mean motion magnitude and period totals.
// Flow: a sample word is accepted only while idle; the window scan, the per-axis trim, divide,
// deviation and square steps and the sixteen-step square root then run before its result is
// loaded; a clear word goes straight to the result. No new word is taken until the result is
// loaded, and the load waits while a previous result word is still not taken downstream.
// Reset: asynchronous, active low; the window, counters and totals clear to zero and the
// configuration registers take their reset values at once.
module gyro_motion_detector (
  input  logic          clk_i,
  input  logic          rst_ni,
  gmd_sample_if.sink    sample_i,
  gmd_result_if.source  result_o,
  gmd_cfg_if.sink       cfg_i
);
  import gmd_pkg::*;

  // Configuration and command signals between the parts.
  cfg_t cfg;
  cmd_t cmd;

  // Register file for the six configuration registers. A write word is always taken;
  // an index beyond the register list is dropped.
  gmd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .wr_ready_o (cfg_i.ready),
    .cfg_o      (cfg)
  );

  // The controller takes a sample word only while it is idle, walks the window one entry
  // a cycle, runs the three axes through the shared divide and square steps, iterates the
  // square root, and finally loads the result word register. That register sits apart
  // from the controller, so a new sample word is accepted while the previous result
  // still waits downstream.
  gmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_opcode_i (sample_i.opcode),
    .in_ready_o  (sample_i.ready),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .cmd_o       (cmd)
  );

  // The datapath holds the window, the per-axis sum, minimum and maximum, the reciprocal
  // multiply that divides by the trimmed count, the square accumulator, the root unit and
  // the period counters with their saturating totals.
  gmd_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_i              (cfg),
    .gyro_x_i           (sample_i.gyro_x),
    .gyro_y_i           (sample_i.gyro_y),
    .gyro_z_i           (sample_i.gyro_z),
    .move_detected_o    (result_o.move_detected),
    .motion_magnitude_o (result_o.motion_magnitude),
    .period_end_o       (result_o.period_end),
    .period_bad_o       (result_o.period_bad),
    .good_total_o       (result_o.good_total),
    .bad_total_o        (result_o.bad_total)
  );

endmodule

/* rtl/core/gmd_checker.sv */
// Port-level checker for the gyro motion detector and its bind to the top level.
module gmd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        move_detected_i,
  input logic [15:0] motion_magnitude_i,
  input logic        period_end_i,
  input logic        period_bad_i,
  input logic [15:0] good_total_i,
  input logic [15:0] bad_total_i
);

  // A result word that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped before it was taken");

  // A stalled result word keeps its magnitude and its two totals.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(motion_magnitude_i) && $stable(good_total_i) && $stable(bad_total_i))
    else $error("stalled result word changed");

  // A period is judged bad only when it ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && period_bad_i |-> period_end_i)
    else $error("bad period flagged without a period end");

  // A finished period always leaves one of the totals above zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && period_end_i |-> (good_total_i != 16'd0) || (bad_total_i != 16'd0))
    else $error("period end without a counted period");

  // No movement can be flagged at zero magnitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (motion_magnitude_i == 16'd0) |-> !move_detected_i)
    else $error("movement flagged at zero magnitude");

endmodule

bind gyro_motion_detector gmd_checker u_gmd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (result_o.valid),
  .out_ready_i        (result_o.ready),
  .move_detected_i    (result_o.move_detected),
  .motion_magnitude_i (result_o.motion_magnitude),
  .period_end_i       (result_o.period_end),
  .period_bad_i       (result_o.period_bad),
  .good_total_i       (result_o.good_total),
  .bad_total_i        (result_o.bad_total)
);
